// ----- sv/ppe_pkg.sv -----
// Shared types and constants for the pole pair estimator.
// Holds the item structs, the controller/datapath command and status
// structs, the register indexes and polarity codes. No dependencies.
package ppe_pkg;

  // Default parameter values.
  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned CYCLE_BITS_DEF = 32;

  // Fixed field widths.
  localparam int unsigned CUR_W      = 16;
  localparam int unsigned ANG_IN_W   = 16;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned ALPHA_W    = 24;
  localparam int unsigned EST_W      = 32;
  localparam int unsigned ROT_W      = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd2;

  // Configuration reset values.
  localparam logic [THR_W-1:0]   THR_RESET   = 15'd50;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 24'd1678;

  // Current polarity codes.
  localparam logic [1:0] POL_NONE = 2'b00;
  localparam logic [1:0] POL_POS  = 2'b01;
  localparam logic [1:0] POL_NEG  = 2'b11;

  // One input item.
  typedef struct packed {
    logic signed [CUR_W-1:0] phase_current;
    logic [ANG_IN_W-1:0]     encoder_angle;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [EST_W-1:0] raw_pole_pairs;
    logic [EST_W-1:0] filtered_pole_pairs;
    logic             estimate_valid;
    logic [EST_W-1:0] cycle_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic take;
    logic upd;
    logic div_start;
    logic div_step;
    logic raw_wr;
    logic diff_wr;
    logic mul_wr;
    logic filt_wr;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic est_ok;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/ppe_ctrl.sv -----
// Controller state machine of the pole pair estimator.
// Sequences sample update, serial division and filter update.
// Depends on ppe_pkg.
module ppe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          enable_i,
  input  logic          clear_i,
  input  ppe_pkg::sts_t sts_i,
  output ppe_pkg::cmd_t cmd_o
);
  import ppe_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_UPD  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_RAW  = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_FILT = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.clear = clear_i;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = enable_i ? S_UPD : S_DONE;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (sts_i.est_ok) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_RAW;
        end
      end
      S_RAW: begin
        cmd_o.raw_wr = 1'b1;
        state_d      = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff_wr = 1'b1;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_wr = 1'b1;
        state_d      = S_FILT;
      end
      S_FILT: begin
        cmd_o.filt_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/ppe_dp.sv -----
// Datapath of the pole pair estimator: rotation unwrap, zero-cross
// counter, serial restoring divider, filter multiplier and output register.
// Depends on ppe_pkg; driven by ppe_ctrl commands.
module ppe_dp #(
  parameter int unsigned ANGLE_BITS = ppe_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CYCLE_BITS = ppe_pkg::CYCLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ppe_pkg::in_item_t           in_item_i,
  input  logic [ppe_pkg::THR_W-1:0]   threshold_i,
  input  logic [ppe_pkg::ALPHA_W-1:0] alpha_i,
  input  ppe_pkg::cmd_t               cmd_i,
  output ppe_pkg::sts_t               sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ppe_pkg::out_item_t          out_item_o
);
  import ppe_pkg::*;

  localparam int unsigned AngExtW  = (ANGLE_BITS > ANG_IN_W) ? ANGLE_BITS : ANG_IN_W;
  localparam int unsigned DW       = ANGLE_BITS + 2;
  localparam int unsigned DivSteps = CYCLE_BITS + ANGLE_BITS + 16;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam int unsigned CycExtW  = (CYCLE_BITS > EST_W) ? CYCLE_BITS : EST_W;
  localparam int unsigned ProdW    = EST_W + ALPHA_W;

  localparam logic signed [DW-1:0]    HalfTurn    = DW'(1) << (ANGLE_BITS - 1);
  localparam logic signed [DW-1:0]    FullTurn    = DW'(1) << ANGLE_BITS;
  localparam logic [ROT_W-1:0]        QuarterTurn = ROT_W'(1) << (ANGLE_BITS - 2);
  localparam logic signed [ROT_W:0]   RotMax      = (ROT_W+1)'((65'd1 << (ROT_W - 1)) - 65'd1);
  localparam logic signed [ROT_W:0]   RotMin      = -RotMax;
  localparam logic [CntW-1:0]         CntLast     = CntW'(DivSteps - 1);
  localparam logic [ProdW:0]          RoundHalf   = (ProdW+1)'(1) << (ALPHA_W - 1);

  // Estimator state.
  in_item_t                samp_q;
  logic [ANGLE_BITS-1:0]   prev_ang_q;
  logic signed [ROT_W-1:0] rot_q;
  logic [CYCLE_BITS-1:0]   cyc_q;
  logic [1:0]              cur_pol_q, prev_pol_q;
  logic [EST_W-1:0]        raw_q, filt_q;
  logic                    valid_q;

  // Divider and filter working registers.
  logic [ROT_W-1:0]        den_q, rem_q;
  logic [EST_W:0]          quo_q;
  logic [CYCLE_BITS-1:0]   dvd_q;
  logic [CntW-1:0]         cnt_q;
  logic [EST_W-1:0]        ad_q;
  logic                    neg_q;
  logic [ProdW-1:0]        prod_q;

  // Output register.
  out_item_t               out_q;
  logic                    out_valid_q;

  // Angle unwrap and saturating rotation sum.
  logic [AngExtW-1:0]      ang_ext;
  logic [ANGLE_BITS-1:0]   ang;
  logic signed [DW-1:0]    d_raw, d_wrap;
  logic signed [ROT_W:0]   rot_sum;
  logic signed [ROT_W-1:0] rot_new;

  always_comb begin
    ang_ext = AngExtW'(samp_q.encoder_angle);
    ang     = ang_ext[ANGLE_BITS-1:0];
    d_raw   = $signed(DW'(ang)) - $signed(DW'(prev_ang_q));
    if (d_raw > HalfTurn) begin
      d_wrap = d_raw - FullTurn;
    end else if (d_raw < -HalfTurn) begin
      d_wrap = d_raw + FullTurn;
    end else begin
      d_wrap = d_raw;
    end
    rot_sum = (ROT_W+1)'(rot_q) + (ROT_W+1)'(d_wrap);
    if (rot_sum > RotMax) begin
      rot_new = RotMax[ROT_W-1:0];
    end else if (rot_sum < RotMin) begin
      rot_new = RotMin[ROT_W-1:0];
    end else begin
      rot_new = rot_sum[ROT_W-1:0];
    end
  end

  // Hysteretic polarity and electrical cycle count.
  logic signed [CUR_W:0] cur_ext, thr_s;
  logic [1:0]            pol_new, prev_pol_new;
  logic                  cyc_inc;

  always_comb begin
    cur_ext = (CUR_W+1)'(samp_q.phase_current);
    thr_s   = $signed({2'b00, threshold_i});
    if (cur_ext > thr_s) begin
      pol_new = POL_POS;
    end else if (cur_ext < -thr_s) begin
      pol_new = POL_NEG;
    end else begin
      pol_new = cur_pol_q;
    end
    cyc_inc      = (prev_pol_q == POL_NEG) && (pol_new == POL_POS) && (cyc_q != '1);
    prev_pol_new = (pol_new != POL_NONE) ? pol_new : prev_pol_q;
  end

  // Estimate gate: more than a quarter turn and at least one cycle.
  logic [ROT_W-1:0] mag;
  assign mag = rot_q[ROT_W-1] ? ROT_W'(-rot_q) : rot_q;

  // One restoring division step per cycle with a saturating quotient.
  logic [ROT_W:0]   rem_sh, rem_sub;
  logic             ge;
  logic [EST_W+1:0] quo_sh;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[CYCLE_BITS-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    quo_sh  = {quo_q, ge};
  end

  // Filter difference and rounded step.
  logic [EST_W:0]   diff;
  logic [ProdW:0]   prod_rnd;
  logic [EST_W-1:0] step;

  always_comb begin
    diff     = {1'b0, raw_q} - {1'b0, filt_q};
    prod_rnd = {1'b0, prod_q} + RoundHalf;
    step     = prod_rnd[ALPHA_W +: EST_W];
  end

  // Saturated cycle count for the result item.
  logic [CycExtW-1:0] cyc_ext;
  logic [EST_W-1:0]   cyc_sat;

  always_comb begin
    cyc_ext = CycExtW'(cyc_q);
    cyc_sat = ((cyc_ext >> EST_W) != '0) ? '1 : cyc_ext[EST_W-1:0];
  end

  // Estimator state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ang_q <= '0;
      rot_q      <= '0;
      cyc_q      <= '0;
      cur_pol_q  <= POL_NONE;
      prev_pol_q <= POL_NONE;
      raw_q      <= '0;
      filt_q     <= '0;
      valid_q    <= 1'b0;
    end else if (cmd_i.clear) begin
      prev_ang_q <= '0;
      rot_q      <= '0;
      cyc_q      <= '0;
      cur_pol_q  <= POL_NONE;
      prev_pol_q <= POL_NONE;
      raw_q      <= '0;
      filt_q     <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        prev_ang_q <= ang;
        rot_q      <= rot_new;
        cur_pol_q  <= pol_new;
        prev_pol_q <= prev_pol_new;
        if (cyc_inc) begin
          cyc_q <= cyc_q + CYCLE_BITS'(1);
        end
      end
      if (cmd_i.raw_wr) begin
        raw_q   <= quo_q[EST_W] ? '1 : quo_q[EST_W-1:0];
        valid_q <= 1'b1;
      end
      if (cmd_i.filt_wr) begin
        if (filt_q == '0) begin
          filt_q <= raw_q;
        end else if (neg_q) begin
          filt_q <= filt_q - step;
        end else begin
          filt_q <= filt_q + step;
        end
      end
    end
  end

  // Sample, divider and multiplier registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      samp_q <= in_item_i;
    end
    if (cmd_i.div_start) begin
      den_q <= mag;
      rem_q <= '0;
      quo_q <= '0;
      dvd_q <= cyc_q;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[ROT_W-1:0] : rem_sh[ROT_W-1:0];
      quo_q <= (quo_sh[EST_W+1:EST_W] != 2'b00) ? {1'b1, {EST_W{1'b0}}}
                                                 : quo_sh[EST_W:0];
      dvd_q <= {dvd_q[CYCLE_BITS-2:0], 1'b0};
    end
    if (cmd_i.diff_wr) begin
      neg_q <= diff[EST_W];
      ad_q  <= diff[EST_W] ? EST_W'(-diff) : diff[EST_W-1:0];
    end
    if (cmd_i.mul_wr) begin
      prod_q <= ProdW'(ad_q) * ProdW'(alpha_i);
    end
    if (cmd_i.out_load) begin
      out_q.raw_pole_pairs      <= raw_q;
      out_q.filtered_pole_pairs <= filt_q;
      out_q.estimate_valid      <= valid_q;
      out_q.cycle_count         <= cyc_sat;
    end
  end

  // Division step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.est_ok   = (mag > QuarterTurn) && (cyc_q != '0);
  assign sts_o.div_last = (cnt_q == CntLast);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

endmodule

// ----- sv/pole_pair_estimator_unit.sv -----
// Pole pair estimator. Each item carries a phase current and a mechanical
// encoder angle; the block returns one result item per input item. An item
// is taken only while the block is idle. A disabled block answers straight
// from its state, a sample that yields no estimate is first used to update
// the state, and a sample that yields an estimate also goes through the
// restoring divider, which produces one quotient bit per cycle, followed by a
// subtract, a 32 x 24 multiply and the filter update. The finished result sits
// in an output register, so the next item can be taken while it waits to be
// read. Configuration writes are taken in every cycle; enabling a disabled
// block clears its state.
module pole_pair_estimator_unit #(
  parameter int unsigned ANGLE_BITS = ppe_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CYCLE_BITS = ppe_pkg::CYCLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ppe_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ppe_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppe_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ppe_pkg::*;

  logic               enable_q;
  logic [THR_W-1:0]   thr_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic               cfg_wr, clear_req;
  cmd_t               cmd;
  sts_t               sts;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  // Enabling a disabled block clears the estimator state.
  assign clear_req = cfg_wr && (cfg_index_i == CFG_ENABLE) && cfg_data_i[0] && !enable_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      thr_q    <= THR_RESET;
      alpha_q  <= ALPHA_RESET;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_ENABLE:    enable_q <= cfg_data_i[0];
        CFG_THRESHOLD: thr_q    <= cfg_data_i[THR_W-1:0];
        CFG_ALPHA:     alpha_q  <= cfg_data_i[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ppe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .enable_i   (enable_q),
    .clear_i    (clear_req),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppe_dp #(
    .ANGLE_BITS (ANGLE_BITS),
    .CYCLE_BITS (CYCLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .threshold_i (thr_q),
    .alpha_i     (alpha_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for pole_pair_estimator_unit.
// Drives sample items and register writes at random pace, predicts every result item
// in place, and compares it field by field. Depends on ppe_pkg.
`timescale 1ns / 1ps

module tb_top;
  import ppe_pkg::*;

  localparam int AB = ANGLE_BITS_DEF;
  localparam int CB = CYCLE_BITS_DEF;
  localparam longint FULL_TURN = 64'sd1 << AB;
  localparam longint HALF_TURN = FULL_TURN / 2;
  localparam longint ROT_LIM = (64'sd1 <<< 47) - 1;
  localparam longint unsigned CYC_MAX = (64'd1 << CB) - 1;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Clock, reset and the ports of the block.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  pole_pair_estimator_unit #(
    .ANGLE_BITS(AB),
    .CYCLE_BITS(CB)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the registers and of the estimator state.
  logic en_cfg = 1'b0;
  logic [THR_W-1:0] thr_cfg = THR_RESET;
  logic [ALPHA_W-1:0] alpha_cfg = ALPHA_RESET;
  logic [AB-1:0] last_angle = '0;
  longint rot_sum = 0;
  longint unsigned elec_cycles = 0;
  logic [1:0] pol_now = POL_NONE;
  logic [1:0] pol_last = POL_NONE;
  logic [EST_W-1:0] raw_q16 = '0;
  logic [EST_W-1:0] filt_q16 = '0;
  logic have_estimate = 1'b0;

  in_item_t pending_samples[$];
  out_item_t expected_readings[$];
  out_item_t want_reading;

  logic in_took = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  logic [ANG_IN_W-1:0] shaft_pos = '0;

  int mismatches = 0;
  int checked = 0;
  int queued_total = 0;
  int ignored_cnt = 0;
  int estimate_cnt = 0;
  int cfg_writes = 0;
  int phases_run = 0;
  int cycle_cnt = 0;

  // Advances the shadow state by one sample and returns the result item it yields.
  function automatic out_item_t track_sample(input in_item_t s);
    longint step_ang;
    longint cur;
    longint lim;
    longint unsigned mag;
    longint unsigned dev;
    longint unsigned nudge;
    logic [127:0] quot;
    out_item_t r;
    if (!en_cfg) begin
      ignored_cnt++;
    end else begin
      // Unwrap the angle step to the shortest signed step; exactly half a turn stays.
      step_ang = longint'({{(64-AB){1'b0}}, s.encoder_angle[AB-1:0]})
               - longint'({{(64-AB){1'b0}}, last_angle});
      if (step_ang > HALF_TURN) begin
        step_ang -= FULL_TURN;
      end else if (step_ang < -HALF_TURN) begin
        step_ang += FULL_TURN;
      end
      rot_sum += step_ang;
      if (rot_sum > ROT_LIM) begin
        rot_sum = ROT_LIM;
      end else if (rot_sum < -ROT_LIM) begin
        rot_sum = -ROT_LIM;
      end
      last_angle = s.encoder_angle[AB-1:0];

      // Hysteretic polarity; a negative to positive change is one electrical cycle.
      cur = longint'($signed(s.phase_current));
      lim = longint'({49'd0, thr_cfg});
      if (cur > lim) begin
        pol_now = POL_POS;
      end else if (cur < -lim) begin
        pol_now = POL_NEG;
      end
      if (pol_last == POL_NEG && pol_now == POL_POS && elec_cycles < CYC_MAX) begin
        elec_cycles++;
      end
      if (pol_now != POL_NONE) begin
        pol_last = pol_now;
      end

      // Estimate once past a quarter turn with at least one cycle counted.
      mag = (rot_sum < 0) ? -rot_sum : rot_sum;
      if (mag * 4 > FULL_TURN && elec_cycles != 0) begin
        quot = ({64'd0, elec_cycles} << (AB + 16)) / {64'd0, mag};
        raw_q16 = (quot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
        have_estimate = 1'b1;
        estimate_cnt++;
        if (filt_q16 == '0) begin
          filt_q16 = raw_q16;
        end else begin
          dev = (raw_q16 >= filt_q16) ? 64'(raw_q16 - filt_q16) : 64'(filt_q16 - raw_q16);
          nudge = (dev * 64'(alpha_cfg) + (64'd1 << 23)) >> 24;
          if (raw_q16 >= filt_q16) begin
            filt_q16 = filt_q16 + nudge[31:0];
          end else begin
            filt_q16 = filt_q16 - nudge[31:0];
          end
        end
      end
    end
    r.raw_pole_pairs = raw_q16;
    r.filtered_pole_pairs = filt_q16;
    r.estimate_valid = have_estimate;
    r.cycle_count = (elec_cycles > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : elec_cycles[31:0];
    return r;
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Accepted items and register writes update the shadow model.
  always @(posedge clk_i) begin
    in_took <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      expected_readings.push_back(track_sample(in_item_i));
    end
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ENABLE: begin
          if (cfg_data_i[0] && !en_cfg) begin
            last_angle = '0;
            rot_sum = 0;
            elec_cycles = 0;
            pol_now = POL_NONE;
            pol_last = POL_NONE;
            raw_q16 = '0;
            filt_q16 = '0;
            have_estimate = 1'b0;
          end
          en_cfg = cfg_data_i[0];
        end
        CFG_THRESHOLD: thr_cfg = cfg_data_i[THR_W-1:0];
        CFG_ALPHA: alpha_cfg = cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Result monitor: each accepted result item is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with none outstanding: raw=%h filt=%h valid=%b cycles=%0d",
                   $realtime, out_item_o.raw_pole_pairs, out_item_o.filtered_pole_pairs,
                   out_item_o.estimate_valid, out_item_o.cycle_count);
        end
      end else begin
        want_reading = expected_readings.pop_front();
        checked++;
        if (out_item_o.raw_pole_pairs !== want_reading.raw_pole_pairs ||
            out_item_o.filtered_pole_pairs !== want_reading.filtered_pole_pairs ||
            out_item_o.estimate_valid !== want_reading.estimate_valid ||
            out_item_o.cycle_count !== want_reading.cycle_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d differs: expected raw=%h filt=%h valid=%b cycles=%0d",
                     $realtime, checked, want_reading.raw_pole_pairs,
                     want_reading.filtered_pole_pairs, want_reading.estimate_valid,
                     want_reading.cycle_count);
            $display("    got raw=%h filt=%h valid=%b cycles=%0d",
                     out_item_o.raw_pole_pairs, out_item_o.filtered_pole_pairs,
                     out_item_o.estimate_valid, out_item_o.cycle_count);
          end
        end
      end
    end
  end

  // Sample driver: feeds the pending items one at a time with random gaps.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (pending_samples.size() != 0) begin
        in_item_i <= pending_samples.pop_front();
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 99) < 3) begin
          in_calm = !in_calm;
        end
        in_gap = in_calm ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side back-pressure, with calm stretches that never stall.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) begin
      out_calm = !out_calm;
    end
    if (out_hold > 0) begin
      out_ready_i <= 1'b0;
      out_hold--;
    end else begin
      out_ready_i <= 1'b1;
      if (!out_calm && $urandom_range(0, 3) == 0) begin
        out_hold = pick_gap();
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles.", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_sample(input logic [CUR_W-1:0] cur, input logic [ANG_IN_W-1:0] ang);
    in_item_t s;
    s.phase_current = cur;
    s.encoder_angle = ang;
    pending_samples.push_back(s);
    shaft_pos = ang;
    queued_total++;
  endtask

  // A stretch of a turning rotor with a triangular phase current, mixed with noise.
  task automatic queue_spin(input int count);
    int pole_cnt;
    int rate;
    int amp;
    int ripple;
    int wave;
    int cur;
    logic [15:0] elec_off;
    logic [15:0] elec;
    pole_cnt = $urandom_range(1, 12);
    rate = $urandom_range(50, 4000);
    if ($urandom_range(0, 1) == 1) begin
      rate = -rate;
    end
    amp = $urandom_range(0, 30000);
    ripple = $urandom_range(0, 600);
    elec_off = 16'($urandom);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 12) begin
        push_sample(16'($urandom), 16'($urandom));
      end else begin
        elec = shaft_pos + rate[15:0];
        elec = 16'(int'(elec) * pole_cnt) + elec_off;
        wave = (elec < 16'h8000) ? int'(elec) - 16384 : 49152 - int'(elec);
        cur = wave * amp / 16384 + int'($urandom_range(0, 2 * ripple)) - ripple;
        push_sample(cur[15:0], shaft_pos + rate[15:0]);
      end
    end
  endtask

  // Waits until every item has gone out and its result has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (pending_samples.size() != 0 || in_valid_i || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; bits above the register width carry random junk.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    int unsigned w;
    case (idx)
      CFG_ENABLE: w = 1;
      CFG_THRESHOLD: w = THR_W;
      CFG_ALPHA: w = ALPHA_W;
      default: w = 0;
    endcase
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= ($urandom() << w) | val;
    cfg_valid_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  // Test sequence.
  initial begin
    int target;
    logic [THR_W-1:0] thr;
    logic [ALPHA_W-1:0] alpha;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Out of reset the block is disabled and must report the cleared state.
    push_sample(16'h7FFF, 16'h4000);
    push_sample(16'h8000, 16'hC000);
    wait_drained();

    write_reg(CFG_THRESHOLD, 32'd100);
    write_reg(CFG_ALPHA, 32'h20_0000);
    write_reg(CFG_ENABLE, 32'd1);

    // Directed: band edges, half-turn steps both ways, wrap at the top of the range,
    // the quarter-turn limit, filter seeding, and rotation in both directions.
    push_sample(16'd0, 16'd0);
    push_sample(16'd100, 16'd1000);
    push_sample(-16'sd100, 16'd2000);
    push_sample(-16'sd101, 16'd34768);
    push_sample(16'd101, 16'd2000);
    push_sample(16'h7FFF, 16'hFFFF);
    push_sample(16'h8000, 16'd30000);
    push_sample(16'd5000, 16'd50000);
    push_sample(-16'sd5000, 16'd10000);
    push_sample(16'd5000, 16'd60000);
    push_sample(-16'sd1, 16'd60000);
    push_sample(16'h8000, 16'd40000);
    push_sample(16'h7FFF, 16'd20000);
    push_sample(16'd0, 16'h8000);
    push_sample(16'h8000, 16'd0);
    push_sample(16'h7FFF, 16'h8000);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          thr = '0;
          alpha = '1;
        end
        1: begin
          thr = '1;
          alpha = '0;
        end
        2: begin
          thr = THR_RESET;
          alpha = ALPHA_RESET;
        end
        default: begin
          thr = ($urandom_range(0, 3) == 0) ? THR_W'($urandom) : THR_W'($urandom_range(0, 3000));
          alpha = ALPHA_W'($urandom);
        end
      endcase
      write_reg(CFG_THRESHOLD, 32'(thr));
      write_reg(CFG_ALPHA, 32'(alpha));

      // Disabled samples are ignored; enabling again clears the state.
      if (phase == 2 || phase == 6) begin
        write_reg(CFG_ENABLE, 32'd0);
        repeat (7) push_sample(16'($urandom), 16'($urandom));
        wait_drained();
        write_reg(CFG_ENABLE, 32'd1);
      end
      // Enabling an enabled block keeps its state.
      if (phase == 4) begin
        write_reg(CFG_ENABLE, 32'd1);
      end
      // The spare index holds no register.
      if (phase == 5) begin
        write_reg(CFG_UNUSED, $urandom);
      end

      target = queued_total + 60;
      while (queued_total < target) begin
        queue_spin($urandom_range(10, 40));
      end
      wait_drained();
      phases_run++;
    end

    mismatches += expected_readings.size();
    $display("Covered %0d samples (%0d while disabled) over %0d random phases, %0d writes.",
             queued_total, ignored_cnt, phases_run, cfg_writes);
    $display("Checked %0d result items, %0d of them carrying a new estimate.",
             checked, estimate_cnt);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
